>>> rtl/core/lpmr_pkg.sv
// shared constants, codes and controller/datapath interface types of the message ring
package lpmr_pkg;

    localparam int STORE_DEPTH  = 4096;
    localparam int HEADER_BYTES = 4;
    localparam int PTR_W        = $clog2(STORE_DEPTH);
    localparam int SIZE_W       = PTR_W + 1;
    localparam int CFG_W        = 13;
    localparam int LEN_W        = 12;
    localparam int LIMIT_W      = 13;
    localparam int MLEN_W       = 8 * HEADER_BYTES;
    localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
    localparam int HDR_LAST     = HEADER_BYTES - 1;
    localparam int RING_MIN     = 16;
    localparam int RING_RESET   = 4096;
    localparam int SIZE_RESET   = (RING_RESET > STORE_DEPTH) ? STORE_DEPTH : RING_RESET;

    typedef enum logic [1:0] {
        CMD_WR_HDR  = 2'd0,
        CMD_WR_DATA = 2'd1,
        CMD_RD_OPEN = 2'd2,
        CMD_RD_DATA = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_EMPTY      = 3'd1,
        STAT_OVERSIZE   = 3'd2,
        STAT_NO_SPACE   = 3'd3,
        STAT_OVER_LIMIT = 3'd4,
        STAT_OUT_OF_SEQ = 3'd5
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic                 sel_ports;
        logic                 latch_item;
        logic                 do_single;
        logic                 wr_start;
        logic                 hdr_wr;
        logic                 wr_finish;
        logic                 rd_start;
        logic                 hdr_rd;
        logic                 rd_eval;
        logic                 rd_issue;
        logic                 rd_finish;
        logic [HDR_IDX_W-1:0] hdr_idx;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic single;
        cmd_t cmd;
        logic out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/length_prefixed_message_ring.sv
// top level of the length-prefixed message ring: controller, datapath and port wiring
//
//  channel   direction  handshake           beat contents
//  s_        in         s_valid / s_ready   cmd, msg_length, data_byte, read_limit
//  m_        out        m_valid / m_ready   status, read_byte, message_length, last
//  cfg_      in         cfg_we              cfg_wdata (ring size), no wait
//
//  write data byte and any refused or out-of-sequence beat: back to back unless m_ is stalled
//  read data byte: through the registered read port of the byte store
//  write header: four header bytes in turn through the single store write port
//  read open: four header reads, then the length check
//  reset is synchronous on aresetn; the store holds no reset and needs no clearing pass
//  a stalled m_ beat holds the finishing step; no s_ beat is taken meanwhile
module length_prefixed_message_ring import lpmr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // ring size register
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    // command beats
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [LEN_W-1:0]   s_msg_length,
    input  logic [7:0]         s_data_byte,
    input  logic [LIMIT_W-1:0] s_read_limit,
    // result beats
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [7:0]         m_read_byte,
    output logic [MLEN_W-1:0]  m_message_length,
    output logic               m_last
);

    // command and status between the sequencer and the datapath
    dp_cmd_t  ctl;
    dp_stat_t stat;

    // sequencer: takes a beat only when idle, answers single beats, or walks header writes,
    // header reads, the length check or the single store read of a payload byte
    lpmr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // datapath: byte store, read and write pointers and cursors, free space and
    // limit checks, and the result register that parts the two channels
    lpmr_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_cmd            (s_cmd),
        .s_msg_length     (s_msg_length),
        .s_data_byte      (s_data_byte),
        .s_read_limit     (s_read_limit),
        .ctl              (ctl),
        .stat             (stat),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_status         (m_status),
        .m_read_byte      (m_read_byte),
        .m_message_length (m_message_length),
        .m_last           (m_last)
    );

endmodule

>>> rtl/core/lpmr_ctrl.sv
// controller state machine of the message ring: sequences header, byte and open steps
module lpmr_ctrl import lpmr_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HOLD  = 6'b000010,
        S_HWR   = 6'b000100,
        S_HRD   = 6'b001000,
        S_HEVAL = 6'b010000,
        S_RDB   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [HDR_IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        ctl           = '0;
        ctl.hdr_idx   = idx_reg;
        ctl.sel_ports = (state_reg == S_IDLE);
        state_next    = state_reg;
        idx_next      = idx_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.latch_item = 1'b1;
                    idx_next       = '0;
                    if (stat.single) begin
                        if (stat.out_free) begin
                            ctl.do_single = 1'b1;
                        end else begin
                            state_next = S_HOLD;
                        end
                    end else begin
                        case (stat.cmd)
                            CMD_WR_HDR: begin
                                ctl.wr_start = 1'b1;
                                state_next   = S_HWR;
                            end
                            CMD_RD_OPEN: begin
                                ctl.rd_start = 1'b1;
                                state_next   = S_HRD;
                            end
                            default: begin
                                ctl.rd_issue = 1'b1;
                                state_next   = S_RDB;
                            end
                        endcase
                    end
                end
            end
            S_HOLD: begin
                if (stat.out_free) begin
                    ctl.do_single = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_HWR: begin
                ctl.hdr_wr = 1'b1;
                if (idx_reg != HDR_IDX_W'(HDR_LAST)) begin
                    idx_next = idx_reg + HDR_IDX_W'(1);
                end else if (stat.out_free) begin
                    ctl.wr_finish = 1'b1;
                    idx_next      = '0;
                    state_next    = S_IDLE;
                end
            end
            S_HRD: begin
                ctl.hdr_rd = 1'b1;
                if (idx_reg != HDR_IDX_W'(HDR_LAST)) begin
                    idx_next = idx_reg + HDR_IDX_W'(1);
                end else begin
                    idx_next   = '0;
                    state_next = S_HEVAL;
                end
            end
            S_HEVAL: begin
                if (stat.out_free) begin
                    ctl.rd_eval = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_RDB: begin
                if (stat.out_free) begin
                    ctl.rd_finish = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/lpmr_dp.sv
// datapath of the message ring: byte store, pointers, checks and result register
module lpmr_dp import lpmr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic [1:0]         s_cmd,
    input  logic [LEN_W-1:0]   s_msg_length,
    input  logic [7:0]         s_data_byte,
    input  logic [LIMIT_W-1:0] s_read_limit,
    input  dp_cmd_t            ctl,
    output dp_stat_t           stat,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [2:0]         m_status,
    output logic [7:0]         m_read_byte,
    output logic [MLEN_W-1:0]  m_message_length,
    output logic               m_last
);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    logic [SIZE_W-1:0]  size_reg;
    logic [PTR_W-1:0]   rp_reg, wp_reg, wc_reg, rc_reg;
    logic [LEN_W-1:0]   wrem_reg;
    logic [LIMIT_W-1:0] rrem_reg;
    logic               wact_reg, ract_reg;

    cmd_t               item_cmd_reg;
    logic [LEN_W-1:0]   item_len_reg;
    logic [7:0]         item_data_reg;
    logic [LIMIT_W-1:0] item_limit_reg;
    logic [MLEN_W-9:0]  hdr_reg;

    logic               out_valid_reg;
    status_t            out_status_reg, out_status_next;
    logic [7:0]         out_rbyte_reg, out_rbyte_next;
    logic [MLEN_W-1:0]  out_mlen_reg, out_mlen_next;
    logic               out_last_reg, out_last_next;

    cmd_t               cur_cmd;
    logic [LEN_W-1:0]   cur_len;
    logic [7:0]         cur_data;
    logic [LIMIT_W-1:0] cur_limit;
    logic [SIZE_W-1:0]  avail, cfg_size;
    logic               oversize, no_space, empty, oos, single, wr_data_ok;
    status_t            single_status;
    logic [MLEN_W-1:0]  hdr_full;
    logic               over_limit, hdr_adv, out_load, out_free;
    logic               mem_we, mem_re;
    logic [7:0]         mem_wdata;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                             input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] q;
        q = SIZE_W'(p) + SIZE_W'(1);
        return (q >= size) ? '0 : q[PTR_W-1:0];
    endfunction

    // current item: straight from the ports on the accept cycle, latched afterwards
    assign cur_cmd   = ctl.sel_ports ? cmd_t'(s_cmd) : item_cmd_reg;
    assign cur_len   = ctl.sel_ports ? s_msg_length : item_len_reg;
    assign cur_data  = ctl.sel_ports ? s_data_byte : item_data_reg;
    assign cur_limit = ctl.sel_ports ? s_read_limit : item_limit_reg;

    assign avail = (wp_reg >= rp_reg) ? size_reg - SIZE_W'(wp_reg - rp_reg)
                                      : SIZE_W'(rp_reg - wp_reg);
    assign oversize = 32'(cur_len) > 32'(size_reg >> 1);
    assign no_space = 32'(avail) <= 32'(cur_len) + 32'(HEADER_BYTES + 1);
    assign empty    = (rp_reg == wp_reg);
    assign cfg_size = (32'(cfg_wdata) > 32'(STORE_DEPTH)) ? SIZE_W'(STORE_DEPTH) :
                      (32'(cfg_wdata) < 32'(RING_MIN))    ? SIZE_W'(RING_MIN)    :
                                                            SIZE_W'(cfg_wdata);

    always_comb begin
        oos           = 1'b0;
        single        = 1'b0;
        single_status = STAT_OK;
        case (cur_cmd)
            CMD_WR_HDR: begin
                oos    = wact_reg;
                single = wact_reg | oversize | no_space;
                if (wact_reg) begin
                    single_status = STAT_OUT_OF_SEQ;
                end else if (oversize) begin
                    single_status = STAT_OVERSIZE;
                end else if (no_space) begin
                    single_status = STAT_NO_SPACE;
                end
            end
            CMD_WR_DATA: begin
                oos    = !wact_reg;
                single = 1'b1;
                if (!wact_reg) begin
                    single_status = STAT_OUT_OF_SEQ;
                end
            end
            CMD_RD_OPEN: begin
                oos    = ract_reg;
                single = ract_reg | empty;
                if (ract_reg) begin
                    single_status = STAT_OUT_OF_SEQ;
                end else if (empty) begin
                    single_status = STAT_EMPTY;
                end
            end
            default: begin
                oos    = !ract_reg;
                single = !ract_reg;
                if (!ract_reg) begin
                    single_status = STAT_OUT_OF_SEQ;
                end
            end
        endcase
    end

    assign wr_data_ok = ctl.do_single && (cur_cmd == CMD_WR_DATA) && !oos;
    assign hdr_adv    = ctl.hdr_wr && ((ctl.hdr_idx != HDR_IDX_W'(HDR_LAST)) || ctl.wr_finish);
    assign hdr_full   = {rdata_reg, hdr_reg};
    assign over_limit = hdr_full > MLEN_W'(cur_limit);

    assign mem_we    = ctl.hdr_wr || wr_data_ok;
    assign mem_re    = ctl.hdr_rd || ctl.rd_issue;
    assign mem_wdata = ctl.hdr_wr ? 8'(32'(cur_len) >> {ctl.hdr_idx, 3'b000}) : cur_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wc_reg] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[rc_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.latch_item) begin
            item_cmd_reg   <= cmd_t'(s_cmd);
            item_len_reg   <= s_msg_length;
            item_data_reg  <= s_data_byte;
            item_limit_reg <= s_read_limit;
        end
        if (ctl.hdr_rd && (ctl.hdr_idx != '0)) begin
            hdr_reg[8*(int'(ctl.hdr_idx)-1) +: 8] <= rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SIZE_W'(SIZE_RESET);
            rp_reg   <= '0;
            wp_reg   <= '0;
            wc_reg   <= '0;
            rc_reg   <= '0;
            wrem_reg <= '0;
            rrem_reg <= '0;
            wact_reg <= 1'b0;
            ract_reg <= 1'b0;
        end else if (cfg_we) begin
            size_reg <= cfg_size;
            rp_reg   <= '0;
            wp_reg   <= '0;
            wc_reg   <= '0;
            rc_reg   <= '0;
            wrem_reg <= '0;
            rrem_reg <= '0;
            wact_reg <= 1'b0;
            ract_reg <= 1'b0;
        end else begin
            if (wr_data_ok) begin
                wc_reg   <= adv(wc_reg, size_reg);
                wrem_reg <= wrem_reg - LEN_W'(1);
                if (wrem_reg == LEN_W'(1)) begin
                    wp_reg   <= adv(wc_reg, size_reg);
                    wact_reg <= 1'b0;
                end
            end
            if (ctl.wr_start) begin
                wc_reg <= wp_reg;
            end
            if (hdr_adv) begin
                wc_reg <= adv(wc_reg, size_reg);
            end
            if (ctl.wr_finish) begin
                if (cur_len == '0) begin
                    wp_reg <= adv(wc_reg, size_reg);
                end else begin
                    wrem_reg <= cur_len;
                    wact_reg <= 1'b1;
                end
            end
            if (ctl.rd_start) begin
                rc_reg <= rp_reg;
            end
            if (ctl.hdr_rd) begin
                rc_reg <= adv(rc_reg, size_reg);
            end
            if (ctl.rd_eval && !over_limit) begin
                if (hdr_full == '0) begin
                    rp_reg <= rc_reg;
                end else begin
                    rrem_reg <= hdr_full[LIMIT_W-1:0];
                    ract_reg <= 1'b1;
                end
            end
            if (ctl.rd_finish) begin
                rc_reg   <= adv(rc_reg, size_reg);
                rrem_reg <= rrem_reg - LIMIT_W'(1);
                if (rrem_reg == LIMIT_W'(1)) begin
                    rp_reg   <= adv(rc_reg, size_reg);
                    ract_reg <= 1'b0;
                end
            end
        end
    end

    // result register
    assign out_load = ctl.do_single || ctl.wr_finish || ctl.rd_eval || ctl.rd_finish;
    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        out_status_next = STAT_OK;
        out_rbyte_next  = '0;
        out_mlen_next   = '0;
        out_last_next   = 1'b0;
        if (ctl.do_single) begin
            out_status_next = single_status;
            out_last_next   = wr_data_ok && (wrem_reg == LEN_W'(1));
        end else if (ctl.wr_finish) begin
            out_last_next = (cur_len == '0);
        end else if (ctl.rd_eval) begin
            out_status_next = over_limit ? STAT_OVER_LIMIT : STAT_OK;
            out_mlen_next   = over_limit ? '0 : hdr_full;
            out_last_next   = !over_limit && (hdr_full == '0);
        end else if (ctl.rd_finish) begin
            out_rbyte_next = rdata_reg;
            out_last_next  = (rrem_reg == LIMIT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= out_status_next;
            out_rbyte_reg  <= out_rbyte_next;
            out_mlen_reg   <= out_mlen_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_read_byte      = out_rbyte_reg;
    assign m_message_length = out_mlen_reg;
    assign m_last           = out_last_reg;

    assign stat.single   = single;
    assign stat.cmd      = cur_cmd;
    assign stat.out_free = out_free;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_ready))
        else $error("result register loaded while a beat is still waiting");

    // read and write ports of the store never collide
    a_port_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("store read and written in the same cycle");

    a_wr_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        wact_reg |-> (wrem_reg != '0))
        else $error("write active with no bytes remaining");

    a_rd_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        ract_reg |-> (rrem_reg != '0))
        else $error("read active with no bytes remaining");

    // a ring size write empties the ring
    a_cfg_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> (!wact_reg && !ract_reg && (rp_reg == wp_reg)))
        else $error("ring not emptied after ring size write");

endmodule

>>> verif/lpmr_reply_checker.sv
// reply checker for the message ring: mirrors ring state and compares every result beat
module lpmr_reply_checker import lpmr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [LEN_W-1:0]   s_msg_length,
    input  logic [7:0]         s_data_byte,
    input  logic [LIMIT_W-1:0] s_read_limit,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [2:0]         m_status,
    input  logic [7:0]         m_read_byte,
    input  logic [MLEN_W-1:0]  m_message_length,
    input  logic               m_last,
    output int                 outstanding,
    output int                 failures
);

    typedef struct packed {
        status_t             status;
        logic [7:0]          rbyte;
        logic [MLEN_W-1:0]   mlen;
        logic                last;
    } ring_reply_t;

    ring_reply_t        replies_due[$];
    logic [7:0]         echo_mem [STORE_DEPTH];
    logic [CFG_W-1:0]   ring_cfg;
    logic [PTR_W-1:0]   rd_ptr, wr_ptr, wr_cur, rd_cur;
    logic [LEN_W-1:0]   wr_rem;
    logic [MLEN_W-1:0]  rd_rem;
    logic               wr_busy, rd_busy;
    int                 fail_count = 0;

    function automatic logic [SIZE_W-1:0] ring_span();
        if (ring_cfg > STORE_DEPTH) return SIZE_W'(STORE_DEPTH);
        if (ring_cfg < RING_MIN) return SIZE_W'(RING_MIN);
        return SIZE_W'(ring_cfg);
    endfunction

    function automatic logic [PTR_W-1:0] next_pos(logic [PTR_W-1:0] p, logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0] q;
        q = {1'b0, p} + SIZE_W'(1);
        return (q >= n) ? '0 : q[PTR_W-1:0];
    endfunction

    task automatic empty_ring();
        rd_ptr = '0;
        wr_ptr = '0;
        wr_cur = '0;
        rd_cur = '0;
        wr_rem = '0;
        rd_rem = '0;
        wr_busy = 1'b0;
        rd_busy = 1'b0;
    endtask

    task automatic report(string what);
        $display("%0t mismatch: %s", $time, what);
        fail_count++;
    endtask

    // works out the reply to one command beat and moves the mirrored ring on
    task automatic predict_reply(input cmd_t c, input logic [LEN_W-1:0] len,
                                 input logic [7:0] db, input logic [LIMIT_W-1:0] lim,
                                 output ring_reply_t r);
        logic [SIZE_W-1:0] n;
        logic [PTR_W-1:0]  p;
        logic [MLEN_W-1:0] hdr;
        int unsigned       room;
        n = ring_span();
        r = '0;
        r.status = STAT_OK;
        case (c)
            CMD_WR_HDR: begin
                if (wr_busy) begin
                    r.status = STAT_OUT_OF_SEQ;
                end else if (len > n / 2) begin
                    r.status = STAT_OVERSIZE;
                end else begin
                    room = (wr_ptr >= rd_ptr) ? n - (wr_ptr - rd_ptr) : rd_ptr - wr_ptr;
                    if (room <= len + HEADER_BYTES + 1) begin
                        r.status = STAT_NO_SPACE;
                    end else begin
                        p = wr_ptr;
                        for (int i = 0; i < HEADER_BYTES; i++) begin
                            echo_mem[p] = 8'(32'(len) >> (8 * i));
                            p = next_pos(p, n);
                        end
                        if (len == 0) begin
                            wr_ptr = p;
                            r.last = 1'b1;
                        end else begin
                            wr_cur = p;
                            wr_rem = len;
                            wr_busy = 1'b1;
                        end
                    end
                end
            end
            CMD_WR_DATA: begin
                if (!wr_busy) begin
                    r.status = STAT_OUT_OF_SEQ;
                end else begin
                    echo_mem[wr_cur] = db;
                    wr_cur = next_pos(wr_cur, n);
                    wr_rem = wr_rem - LEN_W'(1);
                    if (wr_rem == 0) begin
                        wr_ptr = wr_cur;
                        wr_busy = 1'b0;
                        r.last = 1'b1;
                    end
                end
            end
            CMD_RD_OPEN: begin
                if (rd_busy) begin
                    r.status = STAT_OUT_OF_SEQ;
                end else if (rd_ptr == wr_ptr) begin
                    r.status = STAT_EMPTY;
                end else begin
                    p = rd_ptr;
                    hdr = '0;
                    for (int i = 0; i < HEADER_BYTES; i++) begin
                        hdr = hdr | (MLEN_W'(echo_mem[p]) << (8 * i));
                        p = next_pos(p, n);
                    end
                    if (hdr > lim) begin
                        r.status = STAT_OVER_LIMIT;
                    end else begin
                        r.mlen = hdr;
                        if (hdr == 0) begin
                            rd_ptr = p;
                            r.last = 1'b1;
                        end else begin
                            rd_cur = p;
                            rd_rem = hdr;
                            rd_busy = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (!rd_busy) begin
                    r.status = STAT_OUT_OF_SEQ;
                end else begin
                    r.rbyte = echo_mem[rd_cur];
                    rd_cur = next_pos(rd_cur, n);
                    rd_rem = rd_rem - MLEN_W'(1);
                    if (rd_rem == 0) begin
                        rd_ptr = rd_cur;
                        rd_busy = 1'b0;
                        r.last = 1'b1;
                    end
                end
            end
        endcase
    endtask

    task automatic check_reply();
        ring_reply_t want;
        if (replies_due.size() == 0) begin
            report($sformatf("result beat with no command waiting, status %0d", m_status));
        end else begin
            want = replies_due.pop_front();
            if (m_status !== want.status)
                report($sformatf("status expected %0d got %0d", want.status, m_status));
            if (m_read_byte !== want.rbyte)
                report($sformatf("read_byte expected %0d got %0d", want.rbyte, m_read_byte));
            if (m_message_length !== want.mlen)
                report($sformatf("message_length expected %0d got %0d", want.mlen,
                                 m_message_length));
            if (m_last !== want.last)
                report($sformatf("last expected %0d got %0d", want.last, m_last));
        end
    endtask

    always @(posedge aclk) begin
        ring_reply_t r;
        if (!aresetn) begin
            ring_cfg = CFG_W'(RING_RESET);
            empty_ring();
            replies_due.delete();
        end else begin
            // results leave in a later cycle than their command, so compare first
            if (m_valid && m_ready) check_reply();
            if (cfg_we) begin
                ring_cfg = cfg_wdata;
                empty_ring();
            end
            if (s_valid && s_ready) begin
                predict_reply(cmd_t'(s_cmd), s_msg_length, s_data_byte, s_read_limit, r);
                replies_due.push_back(r);
            end
        end
        outstanding <= replies_due.size();
        failures <= fail_count;
    end

endmodule

>>> verif/length_prefixed_message_ring_tb.sv
// testbench top for the message ring: clock, reset, command stimulus and verdict
module length_prefixed_message_ring_tb import lpmr_pkg::*; ();

    // cycles with no beat on either channel before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // rough number of command beats per ring size setting
    localparam int PHASE_BEATS = 150;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd = CMD_WR_HDR;
    logic [LEN_W-1:0]   s_msg_length = '0;
    logic [7:0]         s_data_byte = '0;
    logic [LIMIT_W-1:0] s_read_limit = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_status;
    logic [7:0]         m_read_byte;
    logic [MLEN_W-1:0]  m_message_length;
    logic               m_last;

    int outstanding;
    int failures;

    // what the sender believes is still owed on the open write and the open read
    int unsigned wr_left = 0;
    int unsigned rd_left = 0;
    int unsigned span_now = RING_RESET;
    int          beats_in_phase = 0;
    int          quiet_cycles = 0;
    bit          sender_idles = 1'b0;
    bit          receiver_idles = 1'b0;
    bit          calm = 1'b0;

    // the last result beat taken, used to steer the sender after a header or an open
    status_t           seen_status = STAT_OK;
    logic [MLEN_W-1:0] seen_length = '0;

    length_prefixed_message_ring dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_msg_length     (s_msg_length),
        .s_data_byte      (s_data_byte),
        .s_read_limit     (s_read_limit),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_read_byte      (m_read_byte),
        .m_message_length (m_message_length),
        .m_last           (m_last)
    );

    lpmr_reply_checker reply_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_msg_length     (s_msg_length),
        .s_data_byte      (s_data_byte),
        .s_read_limit     (s_read_limit),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_read_byte      (m_read_byte),
        .m_message_length (m_message_length),
        .m_last           (m_last),
        .outstanding      (outstanding),
        .failures         (failures)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            seen_status <= status_t'(m_status);
            seen_length <= m_message_length;
        end
    end

    // watchdog: any beat on either side restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side back-pressure: random stalls in phases where the receiver idles, none once calm
    initial begin : drain
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (receiver_idles && !calm && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 9) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // one command beat; valid stays up with the payload held until it is taken
    task automatic send_beat(cmd_t c, logic [LEN_W-1:0] len, logic [7:0] db,
                             logic [LIMIT_W-1:0] lim);
        if (sender_idles && !calm && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_cmd        <= c;
        s_msg_length <= len;
        s_data_byte  <= db;
        s_read_limit <= lim;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_in_phase++;
    endtask

    // sender holds off until every owed result beat has been taken
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic put_header(logic [LEN_W-1:0] len);
        send_beat(CMD_WR_HDR, len, 8'($urandom), LIMIT_W'($urandom));
        settle();
        if (seen_status == STAT_OK && len != 0) wr_left = len;
    endtask

    task automatic put_data(logic [7:0] db);
        send_beat(CMD_WR_DATA, LEN_W'($urandom), db, LIMIT_W'($urandom));
        wr_left--;
    endtask

    task automatic open_read(logic [LIMIT_W-1:0] lim);
        send_beat(CMD_RD_OPEN, LEN_W'($urandom), 8'($urandom), lim);
        settle();
        if (seen_status == STAT_OK) rd_left = seen_length;
    endtask

    task automatic get_data();
        send_beat(CMD_RD_DATA, LEN_W'($urandom), 8'($urandom), LIMIT_W'($urandom));
        rd_left--;
    endtask

    // a beat that the block must turn away as out of sequence
    task automatic poke_out_of_seq();
        cmd_t c;
        if ($urandom_range(0, 1) == 0)
            c = (wr_left > 0) ? CMD_WR_HDR : CMD_WR_DATA;
        else
            c = (rd_left > 0) ? CMD_RD_OPEN : CMD_RD_DATA;
        send_beat(c, LEN_W'($urandom), 8'($urandom), LIMIT_W'($urandom));
    endtask

    // ring size write, only ever with nothing owed; the ring comes back empty
    task automatic set_ring(int unsigned v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= CFG_W'(v);
        @(posedge aclk);
        cfg_we  <= 1'b0;
        wr_left = 0;
        rd_left = 0;
        span_now = (v > STORE_DEPTH) ? STORE_DEPTH : ((v < RING_MIN) ? RING_MIN : v);
    endtask

    // mostly short messages, some up to half the ring, some refused as oversize
    function automatic int unsigned pick_length();
        int unsigned half;
        int unsigned r;
        half = span_now / 2;
        r = $urandom_range(0, 99);
        if (r < 8) return 0;
        if (r < 75) return $urandom_range(1, (half < 20) ? half : 20);
        if (r < 88) return $urandom_range(1, (half < 200) ? half : 200);
        if (r < 94) return (half > 256) ? $urandom_range(21, 64) : half;
        return $urandom_range(half + 1, 4095);
    endfunction

    // mostly generous limits; some tight ones to provoke a refused open
    function automatic int unsigned pick_limit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(2048, 8191);
        if (r < 85) return $urandom_range(0, 24);
        return $urandom_range(0, 8191);
    endfunction

    task automatic one_step(int unsigned write_bias);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6)
            poke_out_of_seq();
        else if (wr_left > 0 && r < 55)
            put_data(8'($urandom));
        else if (rd_left > 0 && r < 90)
            get_data();
        else if (wr_left == 0 && $urandom_range(0, 99) < write_bias)
            put_header(LEN_W'(pick_length()));
        else if (rd_left == 0)
            open_read(LIMIT_W'(pick_limit()));
        else if (wr_left > 0)
            put_data(8'($urandom));
        else
            get_data();
    endtask

    // interleaved writes and reads at the current ring size
    task automatic run_phase();
        int unsigned write_bias;
        write_bias = $urandom_range(30, 80);
        sender_idles = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
        beats_in_phase = 0;
        while (beats_in_phase < PHASE_BEATS) one_step(write_bias);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty ring, stray data beats, refused and zero-length messages
        open_read(LIMIT_W'(0));
        send_beat(CMD_RD_DATA, LEN_W'($urandom), 8'($urandom), LIMIT_W'($urandom));
        send_beat(CMD_WR_DATA, LEN_W'($urandom), 8'($urandom), LIMIT_W'($urandom));
        put_header(LEN_W'(4095));
        put_header(LEN_W'(2049));
        put_header(LEN_W'(0));
        open_read(LIMIT_W'(0));
        // header while a write is open, then the payload extremes
        put_header(LEN_W'(3));
        send_beat(CMD_WR_HDR, LEN_W'(5), 8'($urandom), LIMIT_W'($urandom));
        put_data(8'h00);
        put_data(8'hFF);
        put_data(8'hA5);
        // limit below the length leaves the message in place; then open twice
        open_read(LIMIT_W'(2));
        open_read(LIMIT_W'(8191));
        send_beat(CMD_RD_OPEN, LEN_W'($urandom), 8'($urandom), LIMIT_W'(8191));
        while (rd_left > 0) get_data();
        // limit equal to the length is accepted
        put_header(LEN_W'(1));
        put_data(8'h5A);
        open_read(LIMIT_W'(1));
        while (rd_left > 0) get_data();

        run_phase();

        // smallest ring: one message of half the ring leaves no room for another header
        set_ring(16);
        put_header(LEN_W'(8));
        while (wr_left > 0) put_data(8'($urandom));
        put_header(LEN_W'(0));
        open_read(LIMIT_W'(8191));
        while (rd_left > 0) get_data();
        run_phase();

        set_ring(0);
        run_phase();

        // all-ones size saturates to the full store; the largest length is taken
        set_ring(8191);
        put_header(LEN_W'(2048));
        repeat (16) put_data(8'($urandom));
        // a message still being written is not visible to the reader
        open_read(LIMIT_W'(8191));
        // a size write in mid-message empties the ring
        set_ring(8191);
        open_read(LIMIT_W'(8191));
        run_phase();

        set_ring(37);
        run_phase();
        set_ring(15);
        run_phase();
        set_ring(4097);
        run_phase();
        set_ring(300);
        run_phase();

        // last stretch runs flat out with no idling on either side
        set_ring($urandom_range(16, 4096));
        calm = 1'b1;
        run_phase();

        settle();
        repeat (20) @(posedge aclk);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
